### design/assert_macros.svh
// assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: expr");

// ante at one edge implies cons at the next
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

### design/rtu_pkg.sv
// types, constants and crc helper for the rtu request frame receiver
package rtu_pkg;

    localparam int FRAME_LEN   = 7;
    localparam int CRC_COVERED = 5;
    localparam int POS_W       = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_ABORT = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
    } rtu_result_t;

    // one byte of modbus crc-16, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/rtu_frame_engine.sv
// frame capture state, crc accumulation and result formation
module rtu_frame_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 item_accept,
    input  logic                 opcode,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output rtu_pkg::rtu_result_t res_data
);
    import rtu_pkg::*;

    logic [7:0]  own_address_reg;
    logic        receiving_reg, receiving_next;
    pos_t        pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  frame_reg [FRAME_LEN];
    logic        frame_we;
    logic [15:0] crc_upd;
    logic        last_byte;

    assign crc_upd   = crc_byte(receiving_reg ? crc_reg : CRC_INIT, rx_byte);
    assign last_byte = (pos_reg == pos_t'(FRAME_LEN - 1));

    always_comb begin
        receiving_next = receiving_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        frame_we       = 1'b0;
        res_valid      = 1'b0;
        res_data       = '0;
        if (item_accept) begin
            if (opcode == OP_TIMEOUT) begin
                if (receiving_reg) begin
                    receiving_next  = 1'b0;
                    pos_next        = '0;
                    res_valid       = 1'b1;
                    res_data.status = STATUS_ABORT;
                end
            end else if (!receiving_reg) begin
                if (rx_byte == own_address_reg) begin
                    receiving_next = 1'b1;
                    pos_next       = '0;
                    crc_next       = crc_upd;
                end
            end else begin
                frame_we = 1'b1;
                if (pos_reg < pos_t'(CRC_COVERED)) begin
                    crc_next = crc_upd;
                end
                if (last_byte) begin
                    receiving_next = 1'b0;
                    pos_next       = '0;
                    res_valid      = 1'b1;
                    // crc word arrives low byte first
                    res_data.status = (frame_reg[5] == crc_reg[7:0] && rx_byte == crc_reg[15:8])
                                      ? STATUS_GOOD : STATUS_BAD;
                    res_data.function_code = frame_reg[0];
                    res_data.start_address = {frame_reg[1], frame_reg[2]};
                    res_data.quantity      = {frame_reg[3], frame_reg[4]};
                end else begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= 8'd1;
            receiving_reg   <= 1'b0;
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
        end else begin
            if (cfg_wr_en) begin
                own_address_reg <= cfg_wr_data;
            end
            receiving_reg <= receiving_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_reg[pos_reg] <= rx_byte;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_pos_range, aclk, aresetn, pos_reg <= pos_t'(FRAME_LEN - 1))
    `ASSERT_ALWAYS(a_idle_pos_zero, aclk, aresetn, receiving_reg || pos_reg == '0)
    `ASSERT_NEXT(a_result_ends_frame, aclk, aresetn, res_valid, !receiving_reg)

endmodule

### design/rtu_out_skid.sv
// result register with a skid stage so input keeps flowing under output stall
module rtu_out_skid (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rtu_pkg::rtu_result_t in_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtu_pkg::rtu_result_t m_data
);
    import rtu_pkg::*;

    logic        m_valid_reg, m_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    rtu_result_t m_data_reg, m_data_next;
    rtu_result_t skid_data_reg, skid_data_next;
    logic        load_m;

    assign in_ready = !skid_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign load_m   = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        m_data_next     = m_data_reg;
        skid_data_next  = skid_data_reg;
        if (load_m) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = in_valid;
                m_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || m_valid_reg)
    `ASSERT_ALWAYS(a_no_word_when_full, aclk, aresetn, !(skid_valid_reg && in_valid))

endmodule

### design/rtu_request_frame_receiver.sv
// rtu request frame receiver: top level
// the result word for the byte or timeout that ends a frame is registered, then shows on m_valid
// throughput: one word per cycle while s_ready is high; byte crc update and capture finish in the accepting cycle
// a skid stage behind the result register keeps s_ready high through one stalled result
// reset (aresetn low, synchronous): idle, crc preset to ffff, own address 1, output empty
module rtu_request_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_function_code,
    output logic [15:0] m_start_address,
    output logic [15:0] m_quantity
);
    import rtu_pkg::*;

    logic        item_accept;
    logic        res_valid;
    rtu_result_t res_data;
    rtu_result_t out_data;

    assign item_accept = s_valid && s_ready;

    rtu_frame_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_accept (item_accept),
        .opcode      (s_opcode),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    rtu_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (s_ready),
        .in_data  (res_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (out_data)
    );

    assign m_status        = out_data.status;
    assign m_function_code = out_data.function_code;
    assign m_start_address = out_data.start_address;
    assign m_quantity      = out_data.quantity;

endmodule
